>>> design/qot_pkg.sv
// qot_pkg: shared types, codes and helpers for the queue ownership tracker
// used by qot_cell and queue_ownership_tracker_core; no dependencies
`default_nettype none

package qot_pkg;

    localparam int MAX_SUBSCRIBERS_DEF = 16;
    localparam int ID_BITS_DEF         = 16;
    localparam int PORT_ID_W           = 16;

    // ownership codes
    localparam logic [1:0] OWN_NONE   = 2'd0;
    localparam logic [1:0] OWN_SUB    = 2'd1;
    localparam logic [1:0] OWN_SOLE   = 2'd2;
    localparam logic [1:0] OWN_SHARED = 2'd3;

    // error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_RESUB = 2'd2;

    // request codes
    localparam logic OP_SUBSCRIBE   = 1'b0;
    localparam logic OP_UNSUBSCRIBE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPACT,
        ST_REPORT
    } qot_state_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic mark;
        logic shift;
        logic load;
    } qot_cell_ctl_t;

    function automatic logic [1:0] own_state(input logic head_hit,
                                             input logic any_hit,
                                             input logic multi);
        logic [1:0] res;
        if (head_hit)
            res = multi ? OWN_SHARED : OWN_SOLE;
        else if (any_hit)
            res = OWN_SUB;
        else
            res = OWN_NONE;
        return res;
    endfunction

endpackage

`default_nettype wire

>>> design/qot_cell.sv
// qot_cell: one list entry of the subscriber chain with its drop flag
// depends on qot_pkg (qot_cell_ctl_t)
`default_nettype none

module qot_cell #(
    parameter int ID_BITS = qot_pkg::ID_BITS_DEF,
    parameter int CNT_W   = 5,
    parameter int INDEX   = 0
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire qot_pkg::qot_cell_ctl_t  ctl,
    input  wire  [CNT_W-1:0]             count,
    input  wire  [ID_BITS-1:0]           member,
    input  wire  [ID_BITS-1:0]           self_id,
    input  wire                          hole_in,
    input  wire  [ID_BITS-1:0]           right_data,
    input  wire                          right_drop,
    output logic [ID_BITS-1:0]           data,
    output logic                         drop,
    output logic                         hole_out,
    output logic                         self_hit
);

    logic [ID_BITS-1:0] data_reg;
    logic [ID_BITS-1:0] data_next;
    logic               drop_reg;
    logic               drop_next;
    logic               occ;
    logic               shift_here;

    assign occ        = count > CNT_W'(INDEX);
    // first drop in the chain and everything to its right moves one place left
    assign hole_out   = hole_in | drop_reg;
    assign shift_here = ctl.shift & hole_out;

    always_comb
    begin
        data_next = data_reg;
        drop_next = drop_reg;
        if (ctl.mark)
        begin
            drop_next = occ & (data_reg == member);
        end
        else if (shift_here)
        begin
            data_next = right_data;
            drop_next = right_drop;
        end
        else if (ctl.load && (count == CNT_W'(INDEX)))
        begin
            data_next = member;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            drop_reg <= 1'b0;
        else
            drop_reg <= drop_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign drop     = drop_reg;
    assign self_hit = occ & (data_reg == self_id);

endmodule

`default_nettype wire

>>> design/queue_ownership_tracker_core.sv
// queue_ownership_tracker_core: control sequencer over a chain of qot_cell entries
// depends on qot_pkg and qot_cell
// subscribe or refused request: taken in idle, then report state, then the result strobe
// unsubscribe: mark, then one removal per cycle through the chain, then report state
// throughput: busy stays high until the result cycle, next start taken in that cycle
// reset: list count, self id and control clear at once; entries are undefined until written
// the result strobe lasts one cycle and cannot be held off by the receiver
`default_nettype none

module queue_ownership_tracker_core #(
    parameter int MAX_SUBSCRIBERS = qot_pkg::MAX_SUBSCRIBERS_DEF,
    parameter int ID_BITS         = qot_pkg::ID_BITS_DEF,
    parameter int CNT_W           = $clog2(MAX_SUBSCRIBERS + 1)
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    output logic                           busy,
    input  wire                            op,
    input  wire  [qot_pkg::PORT_ID_W-1:0]  member,
    input  wire                            resubscribe,
    input  wire                            self_id_we,
    input  wire  [qot_pkg::PORT_ID_W-1:0]  self_id,
    output logic                           done,
    output logic [1:0]                     state_before,
    output logic [1:0]                     state_after,
    output logic [1:0]                     error,
    output logic [CNT_W-1:0]               subscriber_count
);

    localparam int EXT_W = qot_pkg::PORT_ID_W + ID_BITS;

    qot_pkg::qot_state_t    st_reg, st_next;
    qot_pkg::qot_cell_ctl_t ctl;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ID_BITS-1:0] self_reg, self_next;
    logic [ID_BITS-1:0] member_reg, member_next;
    logic               resub_reg, resub_next;
    logic [1:0]         before_reg, before_next;
    logic [1:0]         after_reg, after_next;
    logic [1:0]         err_reg, err_next;
    logic [CNT_W-1:0]   cnt_out_reg, cnt_out_next;
    logic               done_reg, done_next;

    logic [EXT_W-1:0]   member_ext;
    logic [EXT_W-1:0]   self_ext;
    logic [ID_BITS-1:0] member_id;
    logic [ID_BITS-1:0] member_bus;
    logic               accept;
    logic               any_drop;
    logic               any_hit;
    logic [1:0]         own_now;

    logic [ID_BITS-1:0]       cell_data [MAX_SUBSCRIBERS];
    logic [MAX_SUBSCRIBERS:0] hole;
    logic [MAX_SUBSCRIBERS:0] drop_chain;
    logic [MAX_SUBSCRIBERS-1:0] hit;
    logic [MAX_SUBSCRIBERS-1:0] drops;

    // ids keep their low ID_BITS bits
    assign member_ext = {{ID_BITS{1'b0}}, member};
    assign self_ext   = {{ID_BITS{1'b0}}, self_id};
    assign member_id  = member_ext[ID_BITS-1:0];

    assign accept     = start & (st_reg == qot_pkg::ST_IDLE);
    assign member_bus = (st_reg == qot_pkg::ST_IDLE) ? member_id : member_reg;

    assign hole[0]                     = 1'b0;
    assign drop_chain[MAX_SUBSCRIBERS] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SUBSCRIBERS; gi++)
        begin : g_cell
            logic [ID_BITS-1:0] right_data;
            if (gi == MAX_SUBSCRIBERS - 1)
            begin : g_last
                assign right_data = member_bus;
            end
            else
            begin : g_mid
                assign right_data = cell_data[gi+1];
            end

            qot_cell #(
                .ID_BITS (ID_BITS),
                .CNT_W   (CNT_W),
                .INDEX   (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .count      (count_reg),
                .member     (member_bus),
                .self_id    (self_reg),
                .hole_in    (hole[gi]),
                .right_data (right_data),
                .right_drop (drop_chain[gi+1]),
                .data       (cell_data[gi]),
                .drop       (drop_chain[gi]),
                .hole_out   (hole[gi+1]),
                .self_hit   (hit[gi])
            );
            assign drops[gi] = drop_chain[gi];
        end
    endgenerate

    assign any_drop = |drops;
    assign any_hit  = |hit;
    assign own_now  = qot_pkg::own_state(hit[0], any_hit, count_reg > CNT_W'(1));

    always_comb
    begin
        st_next      = st_reg;
        ctl          = '0;
        count_next   = count_reg;
        member_next  = member_reg;
        resub_next   = resub_reg;
        before_next  = before_reg;
        after_next   = after_reg;
        err_next     = err_reg;
        cnt_out_next = cnt_out_reg;
        done_next    = 1'b0;
        self_next    = self_id_we ? self_ext[ID_BITS-1:0] : self_reg;

        unique case (st_reg)
            qot_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    before_next = own_now;
                    member_next = member_id;
                    resub_next  = resubscribe & op;
                    err_next    = qot_pkg::ERR_OK;
                    st_next     = qot_pkg::ST_REPORT;
                    if (op == qot_pkg::OP_SUBSCRIBE)
                    begin
                        if (count_reg >= CNT_W'(MAX_SUBSCRIBERS))
                        begin
                            err_next = qot_pkg::ERR_FULL;
                        end
                        else
                        begin
                            ctl.load   = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (resubscribe && ((count_reg == '0) ||
                                             (cell_data[0] != member_id)))
                    begin
                        err_next = qot_pkg::ERR_RESUB;
                    end
                    else
                    begin
                        ctl.mark = 1'b1;
                        st_next  = qot_pkg::ST_COMPACT;
                    end
                end
            end
            qot_pkg::ST_COMPACT:
            begin
                // one marked copy leaves the chain per cycle
                if (any_drop)
                begin
                    ctl.shift  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    if (resub_reg && (count_reg < CNT_W'(MAX_SUBSCRIBERS)))
                    begin
                        ctl.load   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    st_next = qot_pkg::ST_REPORT;
                end
            end
            qot_pkg::ST_REPORT:
            begin
                after_next   = own_now;
                cnt_out_next = count_reg;
                done_next    = 1'b1;
                st_next      = qot_pkg::ST_IDLE;
            end
            default:
            begin
                st_next = qot_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= qot_pkg::ST_IDLE;
            count_reg <= '0;
            self_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            count_reg <= count_next;
            self_reg  <= self_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        member_reg  <= member_next;
        resub_reg   <= resub_next;
        before_reg  <= before_next;
        after_reg   <= after_next;
        err_reg     <= err_next;
        cnt_out_reg <= cnt_out_next;
    end

    assign busy             = (st_reg != qot_pkg::ST_IDLE);
    assign done             = done_reg;
    assign state_before     = before_reg;
    assign state_after      = after_reg;
    assign error            = err_reg;
    assign subscriber_count = cnt_out_reg;

    a_done_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(st_reg == qot_pkg::ST_REPORT))
        else $error("result strobe without a report cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SUBSCRIBERS))
        else $error("list count beyond capacity");

    a_compact_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == qot_pkg::ST_COMPACT && any_drop) |=>
            (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("removal did not shorten the list");

    a_no_drop_after_compact: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == qot_pkg::ST_REPORT) |-> !any_drop)
        else $error("marked entry left in the list at report");

endmodule

`default_nettype wire
